/* hdl/sbpk_pkg.sv */
// Package with shared types, constants and pair tables for the band-pair key block.
`default_nettype none
package sbpk_pkg;

  localparam int unsigned NUM_BLOCKS = 6;
  localparam int unsigned BLK_W      = 11;
  localparam int unsigned KEY_W      = 22;
  localparam int unsigned NUM_PAIRS  = 15;
  localparam int unsigned PAIR_W     = 4;
  localparam int unsigned BIDX_W     = 3;

  localparam logic [PAIR_W-1:0] LAST_PAIR     = 4'd14;
  localparam logic [BIDX_W-1:0] FIRST_NARROW  = 3'd4;
  localparam logic [1:0]        KT_FULLTEXT   = 2'd0;
  localparam logic [1:0]        KT_PARAGRAPH  = 2'd1;
  localparam logic [1:0]        KT_SENTENCE   = 2'd2;
  localparam logic [1:0]        KT_INVALID    = 2'd3;

  typedef logic [NUM_BLOCKS-1:0][BLK_W-1:0] blk_arr_t;

  typedef struct packed {
    blk_arr_t   blk;
    logic [1:0] ktype;
    logic       bad;
  } job_t;

  function automatic logic [BIDX_W-1:0] pair_first(input logic [PAIR_W-1:0] p);
    logic [BIDX_W-1:0] r;
    unique case (p)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: r = 3'd0;
      4'd5, 4'd6, 4'd7, 4'd8:       r = 3'd1;
      4'd9, 4'd10, 4'd11:           r = 3'd2;
      4'd12, 4'd13:                 r = 3'd3;
      default:                      r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [BIDX_W-1:0] pair_second(input logic [PAIR_W-1:0] p);
    logic [BIDX_W-1:0] r;
    unique case (p)
      4'd0:                  r = 3'd1;
      4'd1, 4'd5:            r = 3'd2;
      4'd2, 4'd6, 4'd9:      r = 3'd3;
      4'd3, 4'd7, 4'd10, 4'd12: r = 3'd4;
      default:               r = 3'd5;
    endcase
    return r;
  endfunction

  // The lower block's width sets the shift: the last two blocks are 10 bits wide.
  function automatic logic [KEY_W-1:0] pair_key(input blk_arr_t blk,
                                                 input logic [PAIR_W-1:0] p);
    logic [BIDX_W-1:0] i;
    logic [BIDX_W-1:0] j;
    logic [KEY_W-1:0]  hi;
    logic [KEY_W-1:0]  lo;
    i  = pair_first(p);
    j  = pair_second(p);
    hi = {{(KEY_W-BLK_W){1'b0}}, blk[i]};
    lo = {{(KEY_W-BLK_W){1'b0}}, blk[j]};
    if (j >= FIRST_NARROW) begin
      return (hi << (BLK_W-1)) | lo;
    end else begin
      return (hi << BLK_W) | lo;
    end
  endfunction

endpackage
`default_nettype wire

/* hdl/simhash_band_pair_keys_top.sv */
// Top level of the band-pair key block: input stage, job queue and key sequencer.
// The sequencer handles one signature at a time: it steps through the block pairs, stalling
// when a surviving key must wait for the output, and takes the next signature as it releases
// the held last key; a bad type yields a single result with bad_type and tlast set.
// Up to three signatures are buffered ahead of the sequencer.
// Reset: synchronous, active low on rst_n; clears all handshake and sequencer state.
`default_nettype none
module simhash_band_pair_keys_top
  import sbpk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] signature
  input  wire logic [1:0]  in_tuser,   // [1:0] key_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [21:0] band_key, [24:22] first_block,
                                       // [27:25] second_block, [31:28] zero
  output logic [2:0]       out_tuser,  // [1:0] type_out, [2] bad_type
  output logic             out_tlast
);

  logic f_valid;
  logic f_ready;
  job_t f_job;
  logic q_valid;
  logic q_ready;
  job_t q_job;

  sbpk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  sbpk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_job   (f_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_job   (q_job)
  );

  sbpk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_valid),
    .job_ready  (q_ready),
    .job        (q_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* hdl/sbpk_front.sv */
// Input stage: registers a transaction, splits the signature into blocks and flags bad types.
`default_nettype none
module sbpk_front
  import sbpk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  output logic             job_valid,
  input  wire logic        job_ready,
  output job_t             job
);

  logic valid_r;
  job_t job_r;
  job_t job_nxt;

  assign in_tready = !valid_r || job_ready;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_comb begin
    job_nxt.blk[5] = {1'b0, in_tdata[9:0]};
    job_nxt.blk[4] = {1'b0, in_tdata[19:10]};
    job_nxt.blk[3] = in_tdata[30:20];
    job_nxt.blk[2] = in_tdata[41:31];
    job_nxt.blk[1] = in_tdata[52:42];
    job_nxt.blk[0] = in_tdata[63:53];
    job_nxt.ktype  = in_tuser;
    job_nxt.bad    = (in_tuser == KT_INVALID);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/sbpk_queue.sv */
// Two-entry job queue between the input stage and the key sequencer.
`default_nettype none
module sbpk_queue
  import sbpk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire job_t wr_job,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule
`default_nettype wire

/* hdl/sbpk_back.sv */
// Key sequencer: walks the fifteen block pairs, drops repeated keys and drives the result port.
`default_nettype none
module sbpk_back
  import sbpk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  wire job_t        job,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_LAST = 4'b0100,
    ST_ERR  = 4'b1000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  job_t              job_r;
  logic [PAIR_W-1:0] pair_r;
  logic [PAIR_W-1:0] count_r;
  logic [KEY_W-1:0]  keys_r [NUM_PAIRS];

  logic [KEY_W-1:0]  pend_key_r;
  logic [BIDX_W-1:0] pend_i_r;
  logic [BIDX_W-1:0] pend_j_r;
  logic              pend_v_r;

  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [BIDX_W-1:0] out_i_r;
  logic [BIDX_W-1:0] out_j_r;
  logic [1:0]        out_type_r;
  logic              out_bad_r;
  logic              out_last_r;

  logic [KEY_W-1:0]  key;
  logic              dup;
  logic              out_free;
  logic              step;
  logic              load_pend;
  logic              load_err;
  logic              start;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_j_r, out_i_r, out_key_r};
  assign out_tuser  = {out_bad_r, out_type_r};
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;
  assign key        = pair_key(job_r.blk, pair_r);

  // Only entries below the fill count belong to the current transaction.
  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      if ((PAIR_W'(k) < count_r) && (keys_r[k] == key)) begin
        dup = 1'b1;
      end
    end
  end

  // A surviving key is held in the pending register, since only the next survivor or the
  // end of the walk tells whether it is the last one.
  always_comb begin
    step      = 1'b0;
    load_pend = 1'b0;
    load_err  = 1'b0;
    start     = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        start = job_valid;
      end
      ST_RUN: begin
        step      = dup || !pend_v_r || out_free;
        load_pend = step && !dup && pend_v_r;
        if (step && (pair_r == LAST_PAIR)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          load_pend = 1'b1;
          start     = job_valid;
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load_err  = 1'b1;
          start     = job_valid;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (start) begin
      state_nxt = job.bad ? ST_ERR : ST_RUN;
    end
  end

  assign job_ready = start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      count_r     <= '0;
      pair_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        pair_r   <= '0;
        count_r  <= '0;
        pend_v_r <= 1'b0;
      end else if (step) begin
        pair_r <= pair_r + PAIR_W'(1);
        if (!dup) begin
          count_r  <= count_r + PAIR_W'(1);
          pend_v_r <= 1'b1;
        end
      end
      if (load_pend || load_err) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job_r <= job;
    end
    if (step && !dup) begin
      keys_r[count_r] <= key;
      pend_key_r      <= key;
      pend_i_r        <= pair_first(pair_r);
      pend_j_r        <= pair_second(pair_r);
    end
    if (load_pend) begin
      out_key_r  <= pend_key_r;
      out_i_r    <= pend_i_r;
      out_j_r    <= pend_j_r;
      out_type_r <= job_r.ktype;
      out_bad_r  <= 1'b0;
      out_last_r <= (state_r == ST_LAST);
    end else if (load_err) begin
      out_key_r  <= '0;
      out_i_r    <= '0;
      out_j_r    <= '0;
      out_type_r <= KT_FULLTEXT;
      out_bad_r  <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

endmodule
`default_nettype wire
